### src/sqmf_pkg.sv
// ----------------------------------------------------------------------------
// sqmf_pkg
// types, constants and defaults shared by the stereo qmf analysis bank
// ----------------------------------------------------------------------------
package sqmf_pkg;

  localparam int unsigned BlockLenDef = 128;
  localparam int unsigned TapCountDef = 32;

  localparam int unsigned SampleW = 16;
  localparam int unsigned AccW    = 40;
  localparam int unsigned RndBias = 16384;
  localparam int unsigned RndShift = 15;
  localparam int unsigned CoefWords = 8;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 64;

  typedef struct packed {
    logic signed [SampleW-1:0] even_left;
    logic signed [SampleW-1:0] even_right;
    logic signed [SampleW-1:0] odd_left;
    logic signed [SampleW-1:0] odd_right;
  } in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] low_left;
    logic signed [SampleW-1:0] low_right;
    logic signed [SampleW-1:0] high_left;
    logic signed [SampleW-1:0] high_right;
    logic                      block_end;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAIN,
    ST_FIN,
    ST_TLOAD,
    ST_TRUN,
    ST_TDONE
  } state_e;

endpackage

### src/sqmf_lane.sv
// ----------------------------------------------------------------------------
// sqmf_lane
// serial multiply-accumulate lane with saturating accumulator and rounding
// ----------------------------------------------------------------------------
module sqmf_lane (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               clear_i,
  input  logic                               en_i,
  input  logic signed [sqmf_pkg::SampleW-1:0] sample_i,
  input  logic signed [sqmf_pkg::SampleW-1:0] coef_i,
  output logic        [sqmf_pkg::SampleW-1:0] result_o
);
  import sqmf_pkg::*;

  localparam logic signed [AccW:0] AccMax = {2'b00, {(AccW-1){1'b1}}};
  localparam logic signed [AccW:0] AccMin = {2'b11, {(AccW-1){1'b0}}};

  logic signed [AccW-1:0]      acc_q, acc_d;
  logic signed [2*SampleW-1:0] prod;
  logic signed [AccW:0]        sum;
  logic        [AccW:0]        rnd;

  assign prod = sample_i * coef_i;
  assign sum  = {acc_q[AccW-1], acc_q} + (AccW+1)'(prod);

  always_comb begin
    if (sum > AccMax) begin
      acc_d = AccMax[AccW-1:0];
    end else if (sum < AccMin) begin
      acc_d = AccMin[AccW-1:0];
    end else begin
      acc_d = sum[AccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (clear_i) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign rnd      = {acc_q[AccW-1], acc_q} + (AccW+1)'(RndBias);
  assign result_o = rnd[RndShift+SampleW-1:RndShift];

endmodule

### src/sqmf_merge.sv
// ----------------------------------------------------------------------------
// sqmf_merge
// adds overlap history to the four lane results and forms low and high bands
// ----------------------------------------------------------------------------
module sqmf_merge (
  input  logic [sqmf_pkg::SampleW-1:0]   b0_left_i,
  input  logic [sqmf_pkg::SampleW-1:0]   b0_right_i,
  input  logic [sqmf_pkg::SampleW-1:0]   b1_left_i,
  input  logic [sqmf_pkg::SampleW-1:0]   b1_right_i,
  input  logic                           use_hist_i,
  input  logic [2*sqmf_pkg::SampleW-1:0] hist_b0_i,
  input  logic [2*sqmf_pkg::SampleW-1:0] hist_b1_i,
  input  logic                           block_end_i,
  output sqmf_pkg::out_t                 out_o
);
  import sqmf_pkg::*;

  logic [SampleW-1:0] o0l, o0r, o1l, o1r;

  always_comb begin
    o0l = b0_left_i;
    o0r = b0_right_i;
    o1l = b1_left_i;
    o1r = b1_right_i;
    if (use_hist_i) begin
      o0l = o0l + hist_b0_i[SampleW-1:0];
      o0r = o0r + hist_b0_i[2*SampleW-1:SampleW];
      o1l = o1l + hist_b1_i[SampleW-1:0];
      o1r = o1r + hist_b1_i[2*SampleW-1:SampleW];
    end
    out_o.low_left   = o0l + o1l;
    out_o.low_right  = o0r + o1r;
    out_o.high_left  = o0l - o1l;
    out_o.high_right = o0r - o1r;
    out_o.block_end  = block_end_i;
  end

endmodule

### src/stereo_qmf_analysis_bank.sv
// ----------------------------------------------------------------------------
// stereo_qmf_analysis_bank
// two-band polyphase qmf analysis, four serial mac lanes (branch x channel)
// ----------------------------------------------------------------------------
// a pair is accepted only while idle, then the serial mac walks over
//   min(pos+1, TAP_COUNT/2) taps and the result is registered once the
//   output is free; the last pair of a block adds a tail pass over
//   t = 0..H-2 that fills the overlap history, H = TAP_COUNT/2
// reset: samples, history, coefficients and position cleared at once
// ----------------------------------------------------------------------------
module stereo_qmf_analysis_bank #(
  parameter int unsigned FRAME_LEN = sqmf_pkg::BlockLenDef,
  parameter int unsigned TAP_COUNT = sqmf_pkg::TapCountDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sqmf_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sqmf_pkg::out_t                  out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sqmf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sqmf_pkg::CfgDataW-1:0]   cfg_data_i
);
  import sqmf_pkg::*;

  localparam int unsigned H     = TAP_COUNT / 2;
  localparam int unsigned Pairs = FRAME_LEN / 2;
  localparam int unsigned PW    = $clog2(Pairs);
  localparam int unsigned HW    = $clog2(H);
  localparam int unsigned CW    = $clog2(H) + 1;
  localparam int unsigned WW    = 2 * SampleW;

  state_e state_q, state_d;

  logic [CfgDataW-1:0] coef_q [CoefWords];
  logic [WW-1:0]       smp_e_q [H];
  logic [WW-1:0]       smp_o_q [H];
  logic [WW-1:0]       smp_e_new [H];
  logic [WW-1:0]       smp_o_new [H];
  logic [WW-1:0]       win_e_q [H];
  logic [WW-1:0]       win_o_q [H];
  logic [SampleW-1:0]  tap_e [H];
  logic [SampleW-1:0]  tap_o [H];
  logic [SampleW-1:0]  tb_e_q [H];
  logic [SampleW-1:0]  tb_o_q [H];
  logic [SampleW-1:0]  tb_e_sh [H];
  logic [SampleW-1:0]  tb_o_sh [H];
  logic [SampleW-1:0]  cur_e_q [H];
  logic [SampleW-1:0]  cur_o_q [H];
  logic [WW-1:0]       hist_b0_q [H-1];
  logic [WW-1:0]       hist_b1_q [H-1];
  logic [PW-1:0]       pos_q;
  logic [CW-1:0]       cnt_q;
  logic [HW-1:0]       t_q;
  out_t                out_q, merged;
  logic                out_valid_q;

  logic               accept, last, use_hist, out_free, lane_clear, lane_en;
  logic [CW-1:0]      n_main;
  logic [SampleW-1:0] res [4];

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign last        = (pos_q == PW'(Pairs - 1));
  assign use_hist    = (pos_q < PW'(H - 1));
  assign out_free    = !out_valid_q || out_ready_i;
  assign n_main      = (pos_q < PW'(H - 1)) ? CW'(pos_q) + CW'(1) : CW'(H);
  assign lane_clear  = accept || (state_q == ST_TLOAD);
  assign lane_en     = (state_q == ST_MAIN) || (state_q == ST_TRUN);

  always_comb begin
    for (int j = 0; j < H; j++) begin
      tap_e[j] = coef_q[(2*j)/4][16*((2*j)%4) +: 16];
      tap_o[j] = coef_q[(2*j+1)/4][16*((2*j+1)%4) +: 16];
      if (j == 0) begin
        smp_e_new[j] = {in_data_i.even_right, in_data_i.even_left};
        smp_o_new[j] = {in_data_i.odd_right, in_data_i.odd_left};
      end else begin
        smp_e_new[j] = smp_e_q[j-1];
        smp_o_new[j] = smp_o_q[j-1];
      end
      if (j < H - 1) begin
        tb_e_sh[j] = tb_e_q[j+1];
        tb_o_sh[j] = tb_o_q[j+1];
      end else begin
        tb_e_sh[j] = '0;
        tb_o_sh[j] = '0;
      end
    end
  end

  // lanes: branch 0 left/right on even samples with odd taps, branch 1 on odd
  sqmf_lane u_lane0 (
    .clk_i, .rst_ni, .clear_i(lane_clear), .en_i(lane_en),
    .sample_i(win_e_q[0][SampleW-1:0]), .coef_i(cur_o_q[0]), .result_o(res[0])
  );
  sqmf_lane u_lane1 (
    .clk_i, .rst_ni, .clear_i(lane_clear), .en_i(lane_en),
    .sample_i(win_e_q[0][WW-1:SampleW]), .coef_i(cur_o_q[0]), .result_o(res[1])
  );
  sqmf_lane u_lane2 (
    .clk_i, .rst_ni, .clear_i(lane_clear), .en_i(lane_en),
    .sample_i(win_o_q[0][SampleW-1:0]), .coef_i(cur_e_q[0]), .result_o(res[2])
  );
  sqmf_lane u_lane3 (
    .clk_i, .rst_ni, .clear_i(lane_clear), .en_i(lane_en),
    .sample_i(win_o_q[0][WW-1:SampleW]), .coef_i(cur_e_q[0]), .result_o(res[3])
  );

  sqmf_merge u_merge (
    .b0_left_i(res[0]), .b0_right_i(res[1]),
    .b1_left_i(res[2]), .b1_right_i(res[3]),
    .use_hist_i(use_hist),
    .hist_b0_i(hist_b0_q[pos_q[HW-1:0]]),
    .hist_b1_i(hist_b1_q[pos_q[HW-1:0]]),
    .block_end_i(last),
    .out_o(merged)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_MAIN;
      ST_MAIN:  if (cnt_q == CW'(1)) state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) state_d = last ? ST_TLOAD : ST_IDLE;
      end
      ST_TLOAD: state_d = ST_TRUN;
      ST_TRUN:  if (cnt_q == CW'(1)) state_d = ST_TDONE;
      ST_TDONE: state_d = (t_q == HW'(H - 2)) ? ST_IDLE : ST_TLOAD;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CoefWords; k++) coef_q[k] <= '0;
      for (int j = 0; j < H; j++) begin
        smp_e_q[j] <= '0;
        smp_o_q[j] <= '0;
      end
      for (int j = 0; j < H - 1; j++) begin
        hist_b0_q[j] <= '0;
        hist_b1_q[j] <= '0;
      end
      pos_q       <= '0;
      cnt_q       <= '0;
      t_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && (cfg_index_i < CfgIdxW'(CoefWords))) begin
        coef_q[cfg_index_i[$clog2(CoefWords)-1:0]] <= cfg_data_i;
      end
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            for (int j = 0; j < H; j++) begin
              smp_e_q[j] <= smp_e_new[j];
              smp_o_q[j] <= smp_o_new[j];
            end
            cnt_q <= n_main;
          end
        end
        ST_MAIN, ST_TRUN: cnt_q <= cnt_q - CW'(1);
        ST_FIN: begin
          if (out_free) begin
            pos_q <= last ? '0 : pos_q + PW'(1);
            t_q   <= '0;
          end
        end
        ST_TLOAD: cnt_q <= CW'(H - 1) - CW'(t_q);
        ST_TDONE: begin
          hist_b0_q[t_q] <= {res[1], res[0]};
          hist_b1_q[t_q] <= {res[3], res[2]};
          t_q            <= t_q + HW'(1);
        end
        default: ;
      endcase
    end
  end

  // working windows, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int j = 0; j < H; j++) begin
        win_e_q[j] <= smp_e_new[j];
        win_o_q[j] <= smp_o_new[j];
        tb_e_q[j]  <= tap_e[j];
        tb_o_q[j]  <= tap_o[j];
        cur_e_q[j] <= tap_e[j];
        cur_o_q[j] <= tap_o[j];
      end
    end else if (state_q == ST_TLOAD) begin
      for (int j = 0; j < H; j++) begin
        win_e_q[j] <= smp_e_q[j];
        win_o_q[j] <= smp_o_q[j];
        tb_e_q[j]  <= tb_e_sh[j];
        tb_o_q[j]  <= tb_o_sh[j];
        cur_e_q[j] <= tb_e_sh[j];
        cur_o_q[j] <= tb_o_sh[j];
      end
    end else if (lane_en) begin
      for (int j = 0; j < H; j++) begin
        if (j < H - 1) begin
          win_e_q[j] <= win_e_q[j+1];
          win_o_q[j] <= win_o_q[j+1];
          cur_e_q[j] <= cur_e_q[j+1];
          cur_o_q[j] <= cur_o_q[j+1];
        end else begin
          win_e_q[j] <= '0;
          win_o_q[j] <= '0;
          cur_e_q[j] <= '0;
          cur_o_q[j] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FIN) && out_free) out_q <= merged;
  end

endmodule
